FILE: rtl/jqts_pkg.sv
package jqts_pkg;

	localparam int unsigned N_ENTRIES  = 64;
	localparam int unsigned IDX_W      = $clog2(N_ENTRIES);
	localparam int unsigned STEP_W     = 8;
	localparam int unsigned BASE_W     = 7;
	localparam int unsigned SCALE_W    = 13;
	localparam int unsigned PROD_W     = BASE_W + SCALE_W;
	localparam int unsigned DIVIN_W    = 15;
	localparam int unsigned RECIP_W    = 13;
	localparam int unsigned RECIP_SH   = 19;
	localparam int unsigned MUL_W      = DIVIN_W + RECIP_W;
	localparam int unsigned TDATA_O_W  = 24;

	localparam logic [7:0]         Q_LOW_SPLIT = 8'd50;
	localparam logic [7:0]         Q_MAX       = 8'd99;
	localparam logic [SCALE_W-1:0] SCALE_BASE  = 13'd200;
	localparam logic [PROD_W-1:0]  ROUND_ADD   = 20'd50;
	localparam logic [PROD_W-1:0]  SAT_LIMIT   = 20'd25600;
	localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
	localparam logic [STEP_W-1:0]  STEP_MAX    = 8'd255;
	localparam logic [STEP_W-1:0]  STEP_MIN    = 8'd1;

	localparam logic [SCALE_W-1:0] LOW_Q_SCALE [0:49] = '{
		13'd5000, 13'd5000, 13'd2500, 13'd1666, 13'd1250, 13'd1000, 13'd833, 13'd714,
		13'd625,  13'd555,  13'd500,  13'd454,  13'd416,  13'd384,  13'd357, 13'd333,
		13'd312,  13'd294,  13'd277,  13'd263,  13'd250,  13'd238,  13'd227, 13'd217,
		13'd208,  13'd200,  13'd192,  13'd185,  13'd178,  13'd172,  13'd166, 13'd161,
		13'd156,  13'd151,  13'd147,  13'd142,  13'd138,  13'd135,  13'd131, 13'd128,
		13'd125,  13'd121,  13'd119,  13'd116,  13'd113,  13'd111,  13'd108, 13'd106,
		13'd104,  13'd102
	};

	localparam logic [BASE_W-1:0] LUMA_BASE [0:N_ENTRIES-1] = '{
		7'd16,  7'd11,  7'd10,  7'd16,  7'd24,  7'd40,  7'd51,  7'd61,
		7'd12,  7'd12,  7'd14,  7'd19,  7'd26,  7'd58,  7'd60,  7'd55,
		7'd14,  7'd13,  7'd16,  7'd24,  7'd40,  7'd57,  7'd69,  7'd56,
		7'd14,  7'd17,  7'd22,  7'd29,  7'd51,  7'd87,  7'd80,  7'd62,
		7'd18,  7'd22,  7'd37,  7'd56,  7'd68,  7'd109, 7'd103, 7'd77,
		7'd24,  7'd35,  7'd55,  7'd64,  7'd81,  7'd104, 7'd113, 7'd92,
		7'd49,  7'd64,  7'd78,  7'd87,  7'd103, 7'd121, 7'd120, 7'd101,
		7'd72,  7'd92,  7'd95,  7'd98,  7'd112, 7'd100, 7'd103, 7'd99
	};

	localparam logic [BASE_W-1:0] CHROMA_BASE [0:N_ENTRIES-1] = '{
		7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
		7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} jqts_state_t;

	typedef struct packed {
		logic             load;
		logic             issue;
		logic [IDX_W-1:0] idx;
	} jqts_cmd_t;

	typedef struct packed {
		logic advance;
		logic busy;
	} jqts_sts_t;

	function automatic logic [SCALE_W-1:0] quality_scale(input logic [7:0] raw);
		logic [7:0] factor;
		factor = (raw > Q_MAX) ? Q_MAX : raw;
		if (raw < Q_LOW_SPLIT) begin
			quality_scale = LOW_Q_SCALE[raw[5:0]];
		end else begin
			quality_scale = SCALE_BASE - {4'd0, factor, 1'b0};
		end
	endfunction

	function automatic logic [STEP_W-1:0] finish_step(input logic sat,
			input logic [MUL_W-1:0] mul);
		logic [STEP_W-1:0] q;
		q = mul[RECIP_SH +: STEP_W];
		if (sat) begin
			finish_step = STEP_MAX;
		end else if (q == '0) begin
			finish_step = STEP_MIN;
		end else begin
			finish_step = q;
		end
	endfunction

endpackage

FILE: rtl/jqts_ctrl.sv
module jqts_ctrl
	import jqts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  jqts_sts_t sts,
	output jqts_cmd_t cmd
);

	jqts_state_t      state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		s_tready  = 1'b0;
		cmd.load  = 1'b0;
		cmd.issue = 1'b0;
		cmd.idx   = idx_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					idx_d    = '0;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (sts.advance) begin
					cmd.issue = 1'b1;
					idx_d     = idx_q + 1'b1;
					if (idx_q == IDX_W'(N_ENTRIES - 1)) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (!sts.busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/jqts_dp.sv
module jqts_dp
	import jqts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           quality,
	input  jqts_cmd_t            cmd,
	output jqts_sts_t            sts,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_O_W-1:0] m_tdata,
	output logic                 m_tlast
);

	logic [SCALE_W-1:0] scale_q;

	logic               valid_s1, valid_s2, out_valid_q;
	logic [IDX_W-1:0]   idx_s1, idx_s2, out_idx_q;
	logic [PROD_W-1:0]  luma_prod_s1, chroma_prod_s1;
	logic [PROD_W-1:0]  luma_sum, chroma_sum;
	logic [MUL_W-1:0]   luma_mul_s2, chroma_mul_s2;
	logic               luma_sat_s2, chroma_sat_s2;
	logic [STEP_W-1:0]  out_luma_q, out_chroma_q;
	logic               advance;

	assign advance     = !out_valid_q || m_tready;
	assign sts.advance = advance;
	assign sts.busy    = valid_s1 || valid_s2 || out_valid_q;

	assign luma_sum   = luma_prod_s1 + ROUND_ADD;
	assign chroma_sum = chroma_prod_s1 + ROUND_ADD;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			scale_q <= quality_scale(quality);
		end
		if (advance) begin
			idx_s1         <= cmd.idx;
			luma_prod_s1   <= PROD_W'(LUMA_BASE[cmd.idx]) * PROD_W'(scale_q);
			chroma_prod_s1 <= PROD_W'(CHROMA_BASE[cmd.idx]) * PROD_W'(scale_q);
			idx_s2         <= idx_s1;
			luma_sat_s2    <= luma_sum >= SAT_LIMIT;
			chroma_sat_s2  <= chroma_sum >= SAT_LIMIT;
			luma_mul_s2    <= MUL_W'(luma_sum[DIVIN_W-1:0]) * MUL_W'(RECIP_100);
			chroma_mul_s2  <= MUL_W'(chroma_sum[DIVIN_W-1:0]) * MUL_W'(RECIP_100);
			out_idx_q      <= idx_s2;
			out_luma_q     <= finish_step(luma_sat_s2, luma_mul_s2);
			out_chroma_q   <= finish_step(chroma_sat_s2, chroma_mul_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= cmd.issue;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_idx_q == IDX_W'(N_ENTRIES - 1);
	assign m_tdata  = {(TDATA_O_W - IDX_W - 2 * STEP_W)'(0), out_chroma_q, out_luma_q,
		out_idx_q};

endmodule

FILE: rtl/jpeg_quant_table_scaler_unit.sv
// Output: after a quality transaction the block streams 64 entries, one entry per
// cycle while the sink keeps tready high.
// Requests: a new quality request is accepted only once the controller is back in idle,
// after the 64-entry walk has drained through the three scaling stages (multiply,
// reciprocal divide by 100, saturate).
// Reset: arst_n clears the controller and the pipeline valid flags at once.
module jpeg_quant_table_scaler_unit
	import jqts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // [7:0] quality
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_O_W-1:0] m_tdata,  // [5:0] entry_index, [13:6] luma_step,
	                                       // [21:14] chroma_step, [23:22] zero
	output logic                 m_tlast   // last_entry
);

	jqts_cmd_t cmd;
	jqts_sts_t sts;

	jqts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	jqts_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.quality  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: rtl/jqts_checker.sv
module jqts_checker
	import jqts_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [TDATA_O_W-1:0] m_tdata,
	input logic                 m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transaction changed while stalled");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("request taken while entries still pending");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken during a table walk");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[IDX_W-1:0] == IDX_W'(N_ENTRIES - 1))))
		else $error("last flag out of step with entry index");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[IDX_W +: STEP_W] != '0)
			&& (m_tdata[IDX_W + STEP_W +: STEP_W] != '0))
		else $error("quantizer step of zero");

endmodule

bind jpeg_quant_table_scaler_unit jqts_checker u_jqts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
